// ===== hw/rtl/jbt_pkg.sv =====
// jbt_pkg: types, character codes and helper functions for the json byte tokenizer
// no dependencies; used by json_byte_tokenizer
`default_nettype none

package jbt_pkg;

  // width of the saturating string length counter
  localparam int LENGTH_BITS = 16;

  // word lengths, counted in bytes
  localparam logic [2:0] WORD_LEN_TRUE  = 3'd4;
  localparam logic [2:0] WORD_LEN_FALSE = 3'd5;

  // result queue depth
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // character codes
  localparam logic [7:0] CH_LBRACE    = 8'h7b;
  localparam logic [7:0] CH_RBRACE    = 8'h7d;
  localparam logic [7:0] CH_LBRACKET  = 8'h5b;
  localparam logic [7:0] CH_RBRACKET  = 8'h5d;
  localparam logic [7:0] CH_COMMA     = 8'h2c;
  localparam logic [7:0] CH_COLON     = 8'h3a;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0a;
  localparam logic [7:0] CH_FF        = 8'h0c;
  localparam logic [7:0] CH_BS        = 8'h08;
  localparam logic [7:0] CH_CR        = 8'h0d;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_MINUS     = 8'h2d;
  localparam logic [7:0] CH_POINT     = 8'h2e;
  localparam logic [7:0] CH_ZERO      = 8'h30;
  localparam logic [7:0] CH_NINE      = 8'h39;
  localparam logic [7:0] CH_A_LOW     = 8'h61;
  localparam logic [7:0] CH_Z_LOW     = 8'h7a;
  localparam logic [7:0] CH_T_LOW     = 8'h74;
  localparam logic [7:0] CH_F_LOW     = 8'h66;
  localparam logic [7:0] CH_N_LOW     = 8'h6e;
  localparam logic [7:0] CH_B_LOW     = 8'h62;
  localparam logic [7:0] CH_R_LOW     = 8'h72;
  localparam logic [7:0] CH_U_LOW     = 8'h75;
  localparam logic [7:0] CH_E_LOW     = 8'h65;
  localparam logic [7:0] CH_L_LOW     = 8'h6c;
  localparam logic [7:0] CH_S_LOW     = 8'h73;

  // lexer mode
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_STRING = 2'd1,
    MODE_NUMBER = 2'd2,
    MODE_WORD   = 2'd3
  } mode_t;

  // token kinds
  typedef enum logic [3:0] {
    K_LBRACE    = 4'd0,
    K_RBRACE    = 4'd1,
    K_LBRACKET  = 4'd2,
    K_RBRACKET  = 4'd3,
    K_COMMA     = 4'd4,
    K_COLON     = 4'd5,
    K_TAB       = 4'd6,
    K_LETTER    = 4'd7,
    K_BACKSLASH = 4'd8,
    K_STRBYTE   = 4'd9,
    K_STREND    = 4'd10,
    K_INT       = 4'd11,
    K_FLOAT     = 4'd12,
    K_BOOL      = 4'd13,
    K_INVALID   = 4'd14
  } kind_t;

  // one candidate token
  typedef struct packed {
    logic        vld;
    kind_t       kind;
    logic [31:0] value;
  } tok_t;

  // one queued result
  typedef struct packed {
    kind_t       kind;
    logic [31:0] value;
    logic        last;
  } ent_t;

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= CH_ZERO) && (b <= CH_NINE);
  endfunction

  // single-byte token for a byte seen outside any string, number or word
  function automatic tok_t idle_token(input logic [7:0] b);
    tok_t t;
    t.vld   = 1'b1;
    t.kind  = K_LETTER;
    t.value = {24'd0, b};
    case (b)
      CH_LBRACE:    t.kind = K_LBRACE;
      CH_RBRACE:    t.kind = K_RBRACE;
      CH_LBRACKET:  t.kind = K_LBRACKET;
      CH_RBRACKET:  t.kind = K_RBRACKET;
      CH_COMMA:     t.kind = K_COMMA;
      CH_COLON:     t.kind = K_COLON;
      CH_TAB:       t.kind = K_TAB;
      CH_BACKSLASH: t.kind = K_BACKSLASH;
      CH_T_LOW,
      CH_F_LOW:     t.vld  = 1'b0;
      default: begin
        t.vld = (b >= CH_A_LOW) && (b <= CH_Z_LOW);
      end
    endcase
    return t;
  endfunction

  // byte that follows a backslash inside a string
  function automatic logic [7:0] unescape(input logic [7:0] b);
    logic [7:0] d;
    case (b)
      CH_N_LOW: d = CH_LF;
      CH_F_LOW: d = CH_FF;
      CH_B_LOW: d = CH_BS;
      CH_R_LOW: d = CH_CR;
      CH_T_LOW: d = CH_TAB;
      default:  d = b;
    endcase
    return d;
  endfunction

  // expected byte of true or false at a position
  function automatic logic [7:0] word_char(input logic wtrue, input logic [2:0] pos);
    logic [7:0] c;
    if (wtrue) begin
      case (pos)
        3'd0:    c = CH_T_LOW;
        3'd1:    c = CH_R_LOW;
        3'd2:    c = CH_U_LOW;
        default: c = CH_E_LOW;
      endcase
    end else begin
      case (pos)
        3'd0:    c = CH_F_LOW;
        3'd1:    c = CH_A_LOW;
        3'd2:    c = CH_L_LOW;
        3'd3:    c = CH_S_LOW;
        default: c = CH_E_LOW;
      endcase
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/json_byte_tokenizer.sv =====
// json_byte_tokenizer: lexes json text one byte per transaction into tokens
// depends on jbt_pkg
`default_nettype none

// Usage
// in channel: in_valid/in_stall with in_end_of_text and in_text_byte; one
//   transaction per text byte, or one with in_end_of_text set to close any
//   open string, number or word and return to the start state.
// out channel: out_valid/out_stall with out_token_kind, out_token_value and
//   out_last_in_run; one token per transaction, out_last_in_run marks the
//   final token caused by an input byte.
// queueing: a token is registered in the result queue when its byte is accepted.
// throughput: one byte per cycle while each byte gives at most one token and the
//   receiver does not stall; the out channel moves one token a cycle, so a byte
//   that closes a number and also gives its own token sends two tokens. The
//   four-entry result queue raises in_stall while it holds three or more tokens.
// stall: when the receiver stalls, tokens wait in the queue and the input
//   side keeps taking bytes until the queue is nearly full.
// reset: rst_n low empties the queue and returns the lexer to its start state.
module json_byte_tokenizer (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire                 in_end_of_text,
  input  wire  [7:0]          in_text_byte,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [3:0]          out_token_kind,
  output logic signed [31:0]  out_token_value,
  output logic                out_last_in_run
);

  localparam int LB = jbt_pkg::LENGTH_BITS;
  localparam int QA = jbt_pkg::QUEUE_AW;
  localparam int QD = jbt_pkg::QUEUE_DEPTH;

  // lexer state
  jbt_pkg::mode_t   mode_r, mode_nxt;
  logic             esc_r, esc_nxt;
  logic [LB-1:0]    slen_r, slen_nxt;
  logic [2:0]       wpos_r, wpos_nxt;
  logic             wtrue_r, wtrue_nxt;
  logic             wmatch_r, wmatch_nxt;
  logic [31:0]      nmag_r, nmag_nxt;
  logic             nneg_r, nneg_nxt;
  logic             nstop_r, nstop_nxt;
  logic             nfirst_r, nfirst_nxt;
  logic             npoint_r, npoint_nxt;

  // result queue
  jbt_pkg::ent_t    q_r [QD];
  logic [QA-1:0]    hd_r, hd_nxt;
  logic [QA-1:0]    tl_r, tl_nxt;
  logic [QA:0]      cnt_r, cnt_nxt;

  logic             in_acc;
  logic             out_acc;
  logic [7:0]       b;
  logic             b_digit;
  logic             b_numch;
  logic [7:0]       wexp;
  logic [2:0]       wlen;
  logic [2:0]       wpos_inc;
  logic             word_done;
  logic             slen_full;
  logic [LB-1:0]    slen_inc;
  logic [31:0]      slen_ext;
  logic [31:0]      mag_x10;

  jbt_pkg::tok_t    tok0, tok1;
  jbt_pkg::tok_t    close_tok;
  jbt_pkg::ent_t    ent0, ent1;
  logic [1:0]       push_n;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;
  assign b       = in_text_byte;
  assign b_digit = jbt_pkg::is_digit(b);
  assign b_numch = b_digit || (b == jbt_pkg::CH_MINUS) || (b == jbt_pkg::CH_POINT);

  // word matching helpers
  assign wexp      = jbt_pkg::word_char(wtrue_r, wpos_r);
  assign wlen      = wtrue_r ? jbt_pkg::WORD_LEN_TRUE : jbt_pkg::WORD_LEN_FALSE;
  assign wpos_inc  = wpos_r + 3'd1;
  assign word_done = (wpos_inc >= wlen);

  // saturating string length
  assign slen_full = (slen_r == {LB{1'b1}});
  assign slen_inc  = slen_full ? slen_r : slen_r + {{(LB-1){1'b0}}, 1'b1};
  assign slen_ext  = {{(32-LB){1'b0}}, slen_r};

  // magnitude times ten by shift and add
  assign mag_x10 = {nmag_r[28:0], 3'b000} + {nmag_r[30:0], 1'b0};

  // token for a number that is being closed
  always_comb begin
    close_tok.vld = 1'b1;
    if (npoint_r) begin
      close_tok.kind  = jbt_pkg::K_FLOAT;
      close_tok.value = 32'd0;
    end else begin
      close_tok.kind  = jbt_pkg::K_INT;
      close_tok.value = nneg_r ? (32'd0 - nmag_r) : nmag_r;
    end
  end

  // next lexer state
  always_comb begin
    mode_nxt   = mode_r;
    esc_nxt    = esc_r;
    slen_nxt   = slen_r;
    wpos_nxt   = wpos_r;
    wtrue_nxt  = wtrue_r;
    wmatch_nxt = wmatch_r;
    nmag_nxt   = nmag_r;
    nneg_nxt   = nneg_r;
    nstop_nxt  = nstop_r;
    nfirst_nxt = nfirst_r;
    npoint_nxt = npoint_r;
    if (in_end_of_text) begin
      mode_nxt   = jbt_pkg::MODE_IDLE;
      esc_nxt    = 1'b0;
      slen_nxt   = '0;
      wpos_nxt   = 3'd0;
      wtrue_nxt  = 1'b0;
      wmatch_nxt = 1'b1;
      nmag_nxt   = 32'd0;
      nneg_nxt   = 1'b0;
      nstop_nxt  = 1'b0;
      nfirst_nxt = 1'b1;
      npoint_nxt = 1'b0;
    end else begin
      case (mode_r)
        jbt_pkg::MODE_STRING: begin
          if (esc_r) begin
            esc_nxt  = 1'b0;
            slen_nxt = slen_inc;
          end else if (b == jbt_pkg::CH_BACKSLASH) begin
            esc_nxt = 1'b1;
          end else if (b == jbt_pkg::CH_QUOTE) begin
            mode_nxt = jbt_pkg::MODE_IDLE;
            slen_nxt = '0;
          end else begin
            slen_nxt = slen_inc;
          end
        end
        jbt_pkg::MODE_WORD: begin
          if (word_done) begin
            mode_nxt   = jbt_pkg::MODE_IDLE;
            wpos_nxt   = 3'd0;
            wtrue_nxt  = 1'b0;
            wmatch_nxt = 1'b1;
          end else begin
            wpos_nxt   = wpos_inc;
            wmatch_nxt = wmatch_r && (b == wexp);
          end
        end
        jbt_pkg::MODE_NUMBER: begin
          if (b_numch) begin
            if (b_digit) begin
              if (!nstop_r) nmag_nxt = mag_x10 + {28'd0, b[3:0]};
            end else if (b == jbt_pkg::CH_MINUS) begin
              if (nfirst_r) nneg_nxt = 1'b1;
              else          nstop_nxt = 1'b1;
            end else begin
              npoint_nxt = 1'b1;
              nstop_nxt  = 1'b1;
            end
            nfirst_nxt = 1'b0;
          end else begin
            // number closes; the byte then starts from a clean state
            mode_nxt   = jbt_pkg::MODE_IDLE;
            nmag_nxt   = 32'd0;
            nneg_nxt   = 1'b0;
            nstop_nxt  = 1'b0;
            nfirst_nxt = 1'b1;
            npoint_nxt = 1'b0;
            if (b == jbt_pkg::CH_QUOTE) begin
              mode_nxt = jbt_pkg::MODE_STRING;
            end else if ((b == jbt_pkg::CH_T_LOW) || (b == jbt_pkg::CH_F_LOW)) begin
              mode_nxt   = jbt_pkg::MODE_WORD;
              wtrue_nxt  = (b == jbt_pkg::CH_T_LOW);
              wpos_nxt   = 3'd1;
              wmatch_nxt = 1'b1;
            end
          end
        end
        default: begin
          // idle: only start bytes change state
          if (b == jbt_pkg::CH_QUOTE) begin
            mode_nxt = jbt_pkg::MODE_STRING;
          end else if ((b == jbt_pkg::CH_T_LOW) || (b == jbt_pkg::CH_F_LOW)) begin
            mode_nxt   = jbt_pkg::MODE_WORD;
            wtrue_nxt  = (b == jbt_pkg::CH_T_LOW);
            wpos_nxt   = 3'd1;
            wmatch_nxt = 1'b1;
          end else if (b_digit || (b == jbt_pkg::CH_MINUS)) begin
            mode_nxt   = jbt_pkg::MODE_NUMBER;
            nfirst_nxt = 1'b0;
            nneg_nxt   = (b == jbt_pkg::CH_MINUS);
            nmag_nxt   = b_digit ? {28'd0, b[3:0]} : 32'd0;
          end
        end
      endcase
    end
  end

  // tokens caused by the current byte
  always_comb begin
    tok0 = '0;
    tok1 = '0;
    if (in_end_of_text) begin
      case (mode_r)
        jbt_pkg::MODE_STRING: begin
          tok0 = '{1'b1, jbt_pkg::K_STREND, slen_ext};
        end
        jbt_pkg::MODE_NUMBER: begin
          tok0 = close_tok;
        end
        jbt_pkg::MODE_WORD: begin
          tok0 = '{1'b1, jbt_pkg::K_INVALID, 32'd0};
        end
        default: begin
          tok0 = '0;
        end
      endcase
    end else begin
      case (mode_r)
        jbt_pkg::MODE_STRING: begin
          if (esc_r) begin
            tok0 = '{1'b1, jbt_pkg::K_STRBYTE, {24'd0, jbt_pkg::unescape(b)}};
          end else if (b == jbt_pkg::CH_QUOTE) begin
            tok0 = '{1'b1, jbt_pkg::K_STREND, slen_ext};
          end else if (b != jbt_pkg::CH_BACKSLASH) begin
            tok0 = '{1'b1, jbt_pkg::K_STRBYTE, {24'd0, b}};
          end
        end
        jbt_pkg::MODE_WORD: begin
          if (word_done) begin
            if (wmatch_r && (b == wexp)) begin
              tok0 = '{1'b1, jbt_pkg::K_BOOL, {31'd0, wtrue_r}};
            end else begin
              tok0 = '{1'b1, jbt_pkg::K_INVALID, 32'd0};
            end
          end
        end
        jbt_pkg::MODE_NUMBER: begin
          if (!b_numch) begin
            tok0 = close_tok;
            tok1 = jbt_pkg::idle_token(b);
          end
        end
        default: begin
          tok0 = jbt_pkg::idle_token(b);
        end
      endcase
    end
  end

  // queue entries and push count
  always_comb begin
    ent0.kind  = tok0.kind;
    ent0.value = tok0.value;
    ent0.last  = !tok1.vld;
    ent1.kind  = tok1.kind;
    ent1.value = tok1.value;
    ent1.last  = 1'b1;
    push_n     = in_acc ? ({1'b0, tok0.vld} + {1'b0, tok1.vld}) : 2'd0;
  end

  // queue pointers
  always_comb begin
    tl_nxt  = tl_r + QA'(push_n);
    hd_nxt  = out_acc ? hd_r + {{(QA-1){1'b0}}, 1'b1} : hd_r;
    cnt_nxt = cnt_r + (QA+1)'(push_n) - (QA+1)'(out_acc);
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= jbt_pkg::MODE_IDLE;
      esc_r    <= 1'b0;
      slen_r   <= '0;
      wpos_r   <= 3'd0;
      wtrue_r  <= 1'b0;
      wmatch_r <= 1'b1;
      nmag_r   <= 32'd0;
      nneg_r   <= 1'b0;
      nstop_r  <= 1'b0;
      nfirst_r <= 1'b1;
      npoint_r <= 1'b0;
      hd_r     <= '0;
      tl_r     <= '0;
      cnt_r    <= '0;
    end else begin
      if (in_acc) begin
        mode_r   <= mode_nxt;
        esc_r    <= esc_nxt;
        slen_r   <= slen_nxt;
        wpos_r   <= wpos_nxt;
        wtrue_r  <= wtrue_nxt;
        wmatch_r <= wmatch_nxt;
        nmag_r   <= nmag_nxt;
        nneg_r   <= nneg_nxt;
        nstop_r  <= nstop_nxt;
        nfirst_r <= nfirst_nxt;
        npoint_r <= npoint_nxt;
      end
      hd_r  <= hd_nxt;
      tl_r  <= tl_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (in_acc && tok0.vld) q_r[tl_r] <= ent0;
    if (in_acc && tok1.vld) q_r[tl_r + {{(QA-1){1'b0}}, 1'b1}] <= ent1;
  end

  // ports
  assign in_stall        = (cnt_r > (QA+1)'(QD - 2));
  assign out_valid       = (cnt_r != '0);
  assign out_token_kind  = q_r[hd_r].kind;
  assign out_token_value = q_r[hd_r].value;
  assign out_last_in_run = q_r[hd_r].last;

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// tb: self-checking testbench for json_byte_tokenizer
// depends on jbt_pkg and json_byte_tokenizer; sends text bytes, predicts tokens, checks each one
`timescale 1ns / 100ps

module tb;

  localparam int          DEAD_LIMIT  = 4000;
  localparam int          TOTAL_ITEMS = 900;
  localparam logic [31:0] TRUE_TXT    = "true";
  localparam logic [39:0] FALSE_TXT   = "false";

  typedef struct packed {
    jbt_pkg::kind_t kind;
    logic [31:0]    value;
    logic           last;
  } token_rec_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_end_of_text = 1'b0;
  logic [7:0]         in_text_byte = 8'h00;
  logic               out_stall = 1'b0;
  wire                in_stall;
  wire                out_valid;
  wire  [3:0]         out_token_kind;
  wire signed [31:0]  out_token_value;
  wire                out_last_in_run;

  // lexer shadow state
  jbt_pkg::mode_t                  lx_mode;
  logic                            esc_pend;
  logic [jbt_pkg::LENGTH_BITS-1:0] str_len;
  logic [2:0]                      word_pos;
  logic                            word_true;
  logic                            word_ok;
  logic [31:0]                     num_mag;
  logic                            num_neg;
  logic                            num_stopped;
  logic                            num_first;
  logic                            num_point;

  token_rec_t tokens_due[$];
  token_rec_t run_toks[$];

  int  errors = 0;
  int  items_sent = 0;
  int  items_live = 0;
  int  tokens_checked = 0;
  int  burst_left = 0;
  int  stall_left = 0;
  int  dead_cycles = 0;
  bit  stall_on = 1'b0;
  bit  kind_hit[16];

  json_byte_tokenizer u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_end_of_text  (in_end_of_text),
    .in_text_byte    (in_text_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_token_kind  (out_token_kind),
    .out_token_value (out_token_value),
    .out_last_in_run (out_last_in_run)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void lexer_clear();
    lx_mode     = jbt_pkg::MODE_IDLE;
    esc_pend    = 1'b0;
    str_len     = '0;
    word_pos    = 3'd0;
    word_true   = 1'b0;
    word_ok     = 1'b1;
    num_mag     = 32'd0;
    num_neg     = 1'b0;
    num_stopped = 1'b0;
    num_first   = 1'b1;
    num_point   = 1'b0;
  endfunction

  function automatic bit digit_char(input logic [7:0] b);
    return (b >= jbt_pkg::CH_ZERO) && (b <= jbt_pkg::CH_NINE);
  endfunction

  function automatic void add_token(input jbt_pkg::kind_t k, input logic [31:0] v);
    token_rec_t t;
    t.kind  = k;
    t.value = v;
    t.last  = 1'b0;
    run_toks.push_back(t);
  endfunction

  // one byte inside a number: digits accumulate until the first later minus or point
  function automatic void number_step(input logic [7:0] b);
    if (digit_char(b)) begin
      if (!num_stopped) num_mag = num_mag * 32'd10 + 32'(b - jbt_pkg::CH_ZERO);
    end else if (b == jbt_pkg::CH_MINUS) begin
      if (num_first) num_neg = 1'b1;
      else num_stopped = 1'b1;
    end else begin
      num_point   = 1'b1;
      num_stopped = 1'b1;
    end
    num_first = 1'b0;
  endfunction

  function automatic void close_number();
    if (num_point) add_token(jbt_pkg::K_FLOAT, 32'd0);
    else add_token(jbt_pkg::K_INT, num_neg ? (32'd0 - num_mag) : num_mag);
    lexer_clear();
  endfunction

  // byte seen outside any string, number or word
  function automatic void idle_step(input logic [7:0] b);
    case (b)
      jbt_pkg::CH_LBRACE:    add_token(jbt_pkg::K_LBRACE, {24'd0, b});
      jbt_pkg::CH_RBRACE:    add_token(jbt_pkg::K_RBRACE, {24'd0, b});
      jbt_pkg::CH_LBRACKET:  add_token(jbt_pkg::K_LBRACKET, {24'd0, b});
      jbt_pkg::CH_RBRACKET:  add_token(jbt_pkg::K_RBRACKET, {24'd0, b});
      jbt_pkg::CH_COMMA:     add_token(jbt_pkg::K_COMMA, {24'd0, b});
      jbt_pkg::CH_COLON:     add_token(jbt_pkg::K_COLON, {24'd0, b});
      jbt_pkg::CH_TAB:       add_token(jbt_pkg::K_TAB, {24'd0, b});
      jbt_pkg::CH_BACKSLASH: add_token(jbt_pkg::K_BACKSLASH, {24'd0, b});
      jbt_pkg::CH_SPACE, jbt_pkg::CH_LF: ;
      jbt_pkg::CH_QUOTE: begin
        lexer_clear();
        lx_mode = jbt_pkg::MODE_STRING;
      end
      jbt_pkg::CH_T_LOW, jbt_pkg::CH_F_LOW: begin
        lexer_clear();
        lx_mode   = jbt_pkg::MODE_WORD;
        word_true = (b == jbt_pkg::CH_T_LOW);
        word_pos  = 3'd1;
      end
      default: begin
        if (b == jbt_pkg::CH_MINUS || digit_char(b)) begin
          lexer_clear();
          lx_mode = jbt_pkg::MODE_NUMBER;
          number_step(b);
        end else if (b >= jbt_pkg::CH_A_LOW && b <= jbt_pkg::CH_Z_LOW) begin
          add_token(jbt_pkg::K_LETTER, {24'd0, b});
        end
      end
    endcase
  endfunction

  // byte inside a string, with escape decoding and a saturating length
  function automatic void string_step(input logic [7:0] b);
    logic [7:0] d;
    d = b;
    if (esc_pend) begin
      esc_pend = 1'b0;
      case (b)
        jbt_pkg::CH_N_LOW: d = jbt_pkg::CH_LF;
        jbt_pkg::CH_F_LOW: d = jbt_pkg::CH_FF;
        jbt_pkg::CH_B_LOW: d = jbt_pkg::CH_BS;
        jbt_pkg::CH_R_LOW: d = jbt_pkg::CH_CR;
        jbt_pkg::CH_T_LOW: d = jbt_pkg::CH_TAB;
        default:           d = b;
      endcase
    end else if (b == jbt_pkg::CH_BACKSLASH) begin
      esc_pend = 1'b1;
      return;
    end else if (b == jbt_pkg::CH_QUOTE) begin
      add_token(jbt_pkg::K_STREND, 32'(str_len));
      lexer_clear();
      return;
    end
    if (str_len != '1) str_len = str_len + 1'b1;
    add_token(jbt_pkg::K_STRBYTE, {24'd0, d});
  endfunction

  // byte inside true or false; every byte is consumed
  function automatic void word_step(input logic [7:0] b);
    logic [2:0] wlen;
    logic [7:0] want;
    wlen = word_true ? jbt_pkg::WORD_LEN_TRUE : jbt_pkg::WORD_LEN_FALSE;
    if (word_pos < wlen) begin
      if (word_true) want = TRUE_TXT[31 - 8 * word_pos -: 8];
      else want = FALSE_TXT[39 - 8 * word_pos -: 8];
      if (b != want) word_ok = 1'b0;
      word_pos = word_pos + 3'd1;
    end
    if (word_pos >= wlen) begin
      if (word_ok) add_token(jbt_pkg::K_BOOL, word_true ? 32'd1 : 32'd0);
      else add_token(jbt_pkg::K_INVALID, 32'd0);
      lexer_clear();
    end
  endfunction

  // expected tokens for one accepted transaction; returns 0 when the byte had no effect
  function automatic bit predict_tokens(input logic eot, input logic [7:0] b);
    jbt_pkg::mode_t was;
    token_rec_t     t;
    was = lx_mode;
    run_toks.delete();
    if (eot) begin
      case (lx_mode)
        jbt_pkg::MODE_STRING: add_token(jbt_pkg::K_STREND, 32'(str_len));
        jbt_pkg::MODE_NUMBER: close_number();
        jbt_pkg::MODE_WORD:   add_token(jbt_pkg::K_INVALID, 32'd0);
        default: ;
      endcase
      lexer_clear();
    end else begin
      case (lx_mode)
        jbt_pkg::MODE_STRING: string_step(b);
        jbt_pkg::MODE_WORD:   word_step(b);
        jbt_pkg::MODE_NUMBER: begin
          if (b == jbt_pkg::CH_MINUS || b == jbt_pkg::CH_POINT || digit_char(b)) begin
            number_step(b);
          end else begin
            close_number();
            idle_step(b);
          end
        end
        default: idle_step(b);
      endcase
    end
    if (run_toks.size() > 0) begin
      t = run_toks[run_toks.size() - 1];
      t.last = 1'b1;
      run_toks[run_toks.size() - 1] = t;
    end
    foreach (run_toks[i]) tokens_due.push_back(run_toks[i]);
    return !(was == jbt_pkg::MODE_IDLE && lx_mode == jbt_pkg::MODE_IDLE &&
             run_toks.size() == 0);
  endfunction

  // ---------------------------------------------------------------- driving

  // one input transaction, with bursts and random gaps in front
  task automatic send_item(input logic eot, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_end_of_text <= eot;
    in_text_byte   <= b;
    do @(posedge clk); while (in_stall);
    if (predict_tokens(eot, b)) items_live++;
    items_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_item(1'b0, s[i]);
  endtask

  task automatic send_eot();
    send_item(1'b1, 8'($urandom_range(0, 255)));
  endtask

  // sender holds off until every due token has come out
  task automatic wait_for_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (tokens_due.size() != 0);
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_structural();
    send_text("{}[],:\t\\ \nazA");
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hff);
    send_item(1'b0, 8'h7f);
    wait_for_results();
  endtask

  task automatic test_strings();
    // all escapes, escaped quote, escaped backslash, unknown escape
    send_text("\"x\\n\\f\\b\\r\\t\\\"\\\\\\q\"");
    send_text("\"\"");
    send_item(1'b0, jbt_pkg::CH_QUOTE);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hff);
    send_item(1'b0, jbt_pkg::CH_QUOTE);
    wait_for_results();
  endtask

  task automatic test_numbers();
    send_text("-0,2147483647 -2147483648,99999999999]12-34 1.5.2,--5 - 7true ");
    // number closed by a quote that opens a string
    send_text("3\"ab\"");
    wait_for_results();
  endtask

  task automatic test_words();
    send_text("true false trux fAlse t{\"x f12345");
    send_eot();
    wait_for_results();
  endtask

  task automatic test_end_of_text();
    send_eot();
    send_text("\"ab\\");
    send_eot();
    send_text("-42");
    send_eot();
    send_text("1.2");
    send_eot();
    send_text("fa");
    send_eot();
    wait_for_results();
  endtask

  task automatic random_string();
    int n;
    int i;
    send_item(1'b0, jbt_pkg::CH_QUOTE);
    n = $urandom_range(0, 12);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          send_item(1'b0, jbt_pkg::CH_BACKSLASH);
          case ($urandom_range(0, 8))
            0: send_item(1'b0, jbt_pkg::CH_N_LOW);
            1: send_item(1'b0, jbt_pkg::CH_F_LOW);
            2: send_item(1'b0, jbt_pkg::CH_B_LOW);
            3: send_item(1'b0, jbt_pkg::CH_R_LOW);
            4: send_item(1'b0, jbt_pkg::CH_T_LOW);
            5: send_item(1'b0, jbt_pkg::CH_QUOTE);
            6: send_item(1'b0, jbt_pkg::CH_BACKSLASH);
            default: send_item(1'b0, 8'($urandom_range(0, 255)));
          endcase
        end
        2: send_item(1'b0, 8'($urandom_range(0, 255)));
        default: send_item(1'b0, 8'($urandom_range(8'h20, 8'h7e)));
      endcase
    end
    if ($urandom_range(0, 9) == 0) send_eot();
    else send_item(1'b0, jbt_pkg::CH_QUOTE);
  endtask

  task automatic random_number();
    int n;
    int i;
    if ($urandom_range(0, 2) == 0) send_item(1'b0, jbt_pkg::CH_MINUS);
    n = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      send_item(1'b0, 8'($urandom_range(jbt_pkg::CH_ZERO, jbt_pkg::CH_NINE)));
      if ($urandom_range(0, 29) == 0) send_item(1'b0, jbt_pkg::CH_MINUS);
    end
    if ($urandom_range(0, 3) == 0) begin
      send_item(1'b0, jbt_pkg::CH_POINT);
      n = $urandom_range(0, 4);
      for (i = 0; i < n; i++)
        send_item(1'b0, 8'($urandom_range(jbt_pkg::CH_ZERO, jbt_pkg::CH_NINE)));
    end
    case ($urandom_range(0, 5))
      0: send_item(1'b0, jbt_pkg::CH_COMMA);
      1: send_item(1'b0, jbt_pkg::CH_RBRACKET);
      2: send_item(1'b0, jbt_pkg::CH_RBRACE);
      3: send_item(1'b0, jbt_pkg::CH_SPACE);
      4: send_eot();
      default: send_item(1'b0, 8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic random_word();
    string w;
    int    bad;
    int    i;
    if ($urandom_range(0, 1) != 0) w = "true";
    else w = "false";
    bad = ($urandom_range(0, 2) == 0) ? $urandom_range(1, w.len() - 1) : -1;
    for (i = 0; i < w.len(); i++) begin
      if (i == bad) send_item(1'b0, 8'($urandom_range(0, 255)));
      else send_item(1'b0, w[i]);
    end
  endtask

  task automatic test_random_text();
    int i;
    int n;
    while (items_sent < TOTAL_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          case ($urandom_range(0, 7))
            0: send_item(1'b0, jbt_pkg::CH_LBRACE);
            1: send_item(1'b0, jbt_pkg::CH_RBRACE);
            2: send_item(1'b0, jbt_pkg::CH_LBRACKET);
            3: send_item(1'b0, jbt_pkg::CH_RBRACKET);
            4: send_item(1'b0, jbt_pkg::CH_COMMA);
            5: send_item(1'b0, jbt_pkg::CH_COLON);
            6: send_item(1'b0, jbt_pkg::CH_TAB);
            default: send_item(1'b0, jbt_pkg::CH_BACKSLASH);
          endcase
        end
        3, 4, 5, 6: random_string();
        7, 8, 9:    random_number();
        10, 11:     random_word();
        12: send_item(1'b0, $urandom_range(0, 1) ? jbt_pkg::CH_SPACE : jbt_pkg::CH_LF);
        13: send_item(1'b0, 8'($urandom_range(jbt_pkg::CH_A_LOW, jbt_pkg::CH_Z_LOW)));
        14, 15:     send_item(1'b0, 8'($urandom_range(0, 255)));
        16:         send_eot();
        17: begin
          n = $urandom_range(1, 6);
          for (i = 0; i < n; i++) send_item(1'b0, 8'($urandom_range(0, 255)));
        end
        18: wait_for_results();
        default: begin
          // key and colon as in an object member
          random_string();
          send_item(1'b0, jbt_pkg::CH_COLON);
        end
      endcase
    end
    wait_for_results();
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    errors++;
    if (errors <= 40)
      $display("mismatch at %0t: %s expected %0h got %0h", $time, what, want, got);
  endtask

  // compare each token transaction with the oldest one due
  always @(posedge clk) begin
    token_rec_t want;
    if (rst_n && out_valid && !out_stall) begin
      tokens_checked++;
      kind_hit[out_token_kind] = 1'b1;
      if (tokens_due.size() == 0) begin
        report_mismatch("token with none due, kind", 32'd0, 32'(out_token_kind));
      end else begin
        want = tokens_due.pop_front();
        if (out_token_kind !== want.kind)
          report_mismatch("token_kind", 32'(want.kind), 32'(out_token_kind));
        if (out_token_value !== want.value)
          report_mismatch("token_value", want.value, out_token_value);
        if (out_last_in_run !== want.last)
          report_mismatch("last_in_run", 32'(want.last), 32'(out_last_in_run));
      end
    end
  end

  // receiver stall pattern, with long stretches of no stall
  always @(posedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 7))
        0, 1, 2: begin
          stall_on   = 1'b1;
          stall_left = $urandom_range(1, 6);
        end
        7: begin
          stall_on   = 1'b0;
          stall_left = $urandom_range(30, 60);
        end
        default: begin
          stall_on   = 1'b0;
          stall_left = $urandom_range(1, 8);
        end
      endcase
    end
    stall_left--;
    out_stall <= stall_on;
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) dead_cycles <= 0;
    else dead_cycles <= dead_cycles + 1;
    if (dead_cycles >= DEAD_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", DEAD_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    int kinds;
    lexer_clear();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_structural();
    test_strings();
    test_numbers();
    test_words();
    test_end_of_text();
    test_random_text();
    wait_for_results();
    repeat (20) @(posedge clk);
    kinds = 0;
    foreach (kind_hit[k]) if (kind_hit[k]) kinds++;
    $display("run covered %0d input bytes (%0d with effect) and %0d checked tokens",
             items_sent, items_live, tokens_checked);
    $display("token kinds seen: %0d of 15, with bursts, gaps and output stalls", kinds);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
